### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the descriptor parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ESDP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("es descriptor parser check failed");

// Next-cycle implication, checked outside reset
`define ESDP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("es descriptor parser check failed");

// Next-cycle implication, checked during reset as well
`define ESDP_ASSERT_NEXT_ANY(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("es descriptor parser check failed");

`endif

### sv/esdp_pkg.sv
// ----------------------------------------------------------------------------
// esdp_pkg
// Field codes, status codes and register indexes of the ES descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package esdp_pkg;

   // Result field codes
   localparam logic [3:0] FC_ES_ID      = 4'd0;
   localparam logic [3:0] FC_FLAGS      = 4'd1;
   localparam logic [3:0] FC_DEPENDS_ID = 4'd2;
   localparam logic [3:0] FC_URL_BYTE   = 4'd3;
   localparam logic [3:0] FC_OCR_ID     = 4'd4;
   localparam logic [3:0] FC_OBJ_TYPE   = 4'd5;
   localparam logic [3:0] FC_STREAM     = 4'd6;
   localparam logic [3:0] FC_BUF_SIZE   = 4'd7;
   localparam logic [3:0] FC_MAX_RATE   = 4'd8;
   localparam logic [3:0] FC_AVG_RATE   = 4'd9;
   localparam logic [3:0] FC_INFO_BYTE  = 4'd10;
   localparam logic [3:0] FC_END        = 4'd11;

   // Result status codes
   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_BAD_ES_TAG    = 2'd1;
   localparam logic [1:0] ST_BAD_LENGTH    = 2'd2;
   localparam logic [1:0] ST_NO_CONFIG_TAG = 2'd3;

   // Register indexes (byte address bits 3:2)
   localparam logic [1:0] REG_ES_TAG      = 2'd0;
   localparam logic [1:0] REG_CONFIG_TAG  = 2'd1;
   localparam logic [1:0] REG_INFO_TAG    = 2'd2;

   // Decoder config descriptor length without specific info
   localparam logic [31:0] DC_FIXED_LEN = 32'd13;

endpackage

`default_nettype wire

### sv/es_descriptor_parser.sv
// ----------------------------------------------------------------------------
// es_descriptor_parser
// Byte-serial parser for an MPEG-4 ES_Descriptor and its decoder config.
// ----------------------------------------------------------------------------
// The parser takes one descriptor byte per cycle while req_ready is high and gives
// at most one result item per byte, registered and shown in the cycle after the
// byte is taken. Each byte updates the parse state (the widest path is the 32-bit
// size compare against the remaining frame count); the result sits in an output
// register, so req_ready drops only while a result is held and rsp_ready is low.
`default_nettype none

module es_descriptor_parser
   import esdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_start,
   input  wire logic [31:0] req_bytes_available,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_field_code,
   output logic [31:0]      rsp_field_value,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_ES_SIZE, PH_ES_ID, PH_FLAGS, PH_DEP, PH_URL_LEN, PH_URL, PH_OCR,
      PH_DC_TAG, PH_DC_SIZE, PH_OBJ, PH_STREAM, PH_BUFSZ, PH_MAXR, PH_AVGR,
      PH_DSI_TAG, PH_DSI_SIZE, PH_DSI_DATA
   } phase_type;

   // Pick the next optional ES field at or after the given one
   function automatic phase_type next_optional(phase_type from, logic [2:0] flags);
      phase_type nxt;
      priority if (from == PH_DEP && flags[2]) begin
         nxt = PH_DEP;
      end else if ((from == PH_DEP || from == PH_URL_LEN) && flags[1]) begin
         nxt = PH_URL_LEN;
      end else if (flags[0]) begin
         nxt = PH_OCR;
      end else begin
         nxt = PH_DC_TAG;
      end
      return nxt;
   endfunction

   // Registers
   logic [7:0]  es_tag_ff, config_tag_ff, info_tag_ff;
   phase_type   phase_ff, phase_in;
   logic [31:0] size_acc_ff, size_acc_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  count_ff, count_in;
   logic [2:0]  flags_ff, flags_in;
   logic [7:0]  url_ff, url_in;
   logic [31:0] config_len_ff, config_len_in;
   logic [31:0] info_ff, info_in;
   logic [31:0] remain_ff, remain_in;
   logic        rsp_valid_ff;
   logic [3:0]  rsp_code_ff;
   logic [31:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_last_ff;

   // Result of the current byte
   logic        res_valid;
   logic [3:0]  res_code;
   logic [31:0] res_value;
   logic [1:0]  res_status;
   logic        res_last;

   logic        req_accept;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [7:0]  b;
   logic [31:0] col_base, col_shift, remain_dec, size_shifted;
   logic [2:0]  col_count;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign b          = req_data_byte;

   // Big-endian field collection shared by the multi-byte fields
   assign col_base   = (count_ff == 3'd0) ? 32'd0 : shift_ff;
   assign col_shift  = {col_base[23:0], b};
   assign col_count  = count_ff + 3'd1;
   assign remain_dec = (remain_ff != 32'd0) ? remain_ff - 32'd1 : 32'd0;
   assign size_shifted = {size_acc_ff[24:0], b[6:0]};

   // Parse one byte
   always_comb begin
      phase_in      = phase_ff;
      size_acc_in   = size_acc_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      url_in        = url_ff;
      config_len_in = config_len_ff;
      info_in       = info_ff;
      remain_in     = remain_ff;
      res_valid     = 1'b0;
      res_code      = FC_END;
      res_value     = 32'd0;
      res_status    = ST_OK;
      res_last      = 1'b0;

      if (req_frame_start) begin
         // restart on a new frame
         remain_in     = (req_bytes_available != 32'd0) ? req_bytes_available - 32'd1
                                                        : 32'd0;
         size_acc_in   = 32'd0;
         shift_in      = 32'd0;
         count_in      = 3'd0;
         flags_in      = 3'd0;
         url_in        = 8'd0;
         config_len_in = 32'd0;
         info_in       = 32'd0;
         if (b != es_tag_ff) begin
            phase_in   = PH_IDLE;
            res_valid  = 1'b1;
            res_status = ST_BAD_ES_TAG;
            res_last   = 1'b1;
         end else begin
            phase_in = PH_ES_SIZE;
         end
      end else if (phase_ff != PH_IDLE) begin
         remain_in = remain_dec;
         unique case (phase_ff)
            PH_ES_SIZE: begin
               size_acc_in = size_shifted;
               if (!b[7]) begin
                  if (size_shifted > remain_dec) begin
                     phase_in   = PH_IDLE;
                     res_valid  = 1'b1;
                     res_status = ST_BAD_LENGTH;
                     res_last   = 1'b1;
                  end else begin
                     phase_in = PH_ES_ID;
                  end
               end
            end
            PH_ES_ID: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd2) begin
                  count_in  = 3'd0;
                  phase_in  = PH_FLAGS;
                  res_valid = 1'b1;
                  res_code  = FC_ES_ID;
                  res_value = col_shift;
               end
            end
            PH_FLAGS: begin
               flags_in  = b[7:5];
               phase_in  = next_optional(PH_DEP, b[7:5]);
               res_valid = 1'b1;
               res_code  = FC_FLAGS;
               res_value = {24'd0, b};
            end
            PH_DEP: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd2) begin
                  count_in  = 3'd0;
                  phase_in  = next_optional(PH_URL_LEN, flags_ff);
                  res_valid = 1'b1;
                  res_code  = FC_DEPENDS_ID;
                  res_value = col_shift;
               end
            end
            PH_URL_LEN: begin
               url_in   = b;
               phase_in = (b != 8'd0) ? PH_URL : next_optional(PH_OCR, flags_ff);
            end
            PH_URL: begin
               url_in = url_ff - 8'd1;
               if (url_ff == 8'd1) begin
                  phase_in = next_optional(PH_OCR, flags_ff);
               end
               res_valid = 1'b1;
               res_code  = FC_URL_BYTE;
               res_value = {24'd0, b};
            end
            PH_OCR: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd2) begin
                  count_in  = 3'd0;
                  phase_in  = PH_DC_TAG;
                  res_valid = 1'b1;
                  res_code  = FC_OCR_ID;
                  res_value = col_shift;
               end
            end
            PH_DC_TAG: begin
               if (b != config_tag_ff) begin
                  phase_in   = PH_IDLE;
                  res_valid  = 1'b1;
                  res_status = ST_NO_CONFIG_TAG;
                  res_last   = 1'b1;
               end else begin
                  config_len_in = 32'd0;
                  phase_in      = PH_DC_SIZE;
               end
            end
            PH_DC_SIZE: begin
               config_len_in = {config_len_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  phase_in = PH_OBJ;
               end
            end
            PH_OBJ: begin
               phase_in  = PH_STREAM;
               res_valid = 1'b1;
               res_code  = FC_OBJ_TYPE;
               res_value = {24'd0, b};
            end
            PH_STREAM: begin
               phase_in  = PH_BUFSZ;
               res_valid = 1'b1;
               res_code  = FC_STREAM;
               res_value = {25'd0, b[7:1]};
            end
            PH_BUFSZ: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd3) begin
                  count_in  = 3'd0;
                  phase_in  = PH_MAXR;
                  res_valid = 1'b1;
                  res_code  = FC_BUF_SIZE;
                  res_value = col_shift;
               end
            end
            PH_MAXR: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd4) begin
                  count_in  = 3'd0;
                  phase_in  = PH_AVGR;
                  res_valid = 1'b1;
                  res_code  = FC_MAX_RATE;
                  res_value = col_shift;
               end
            end
            PH_AVGR: begin
               shift_in = col_shift;
               count_in = col_count;
               if (col_count >= 3'd4) begin
                  count_in  = 3'd0;
                  res_valid = 1'b1;
                  res_code  = FC_AVG_RATE;
                  res_value = col_shift;
                  if (config_len_ff > DC_FIXED_LEN) begin
                     phase_in = PH_DSI_TAG;
                  end else begin
                     phase_in = PH_IDLE;
                     res_last = 1'b1;
                  end
               end
            end
            PH_DSI_TAG: begin
               if (b != info_tag_ff) begin
                  phase_in  = PH_IDLE;
                  res_valid = 1'b1;
                  res_last  = 1'b1;
               end else begin
                  info_in  = 32'd0;
                  phase_in = PH_DSI_SIZE;
               end
            end
            PH_DSI_SIZE: begin
               info_in = {info_ff[24:0], b[6:0]};
               if (!b[7]) begin
                  if ({info_ff[24:0], b[6:0]} == 32'd0) begin
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     res_last  = 1'b1;
                  end else begin
                     phase_in = PH_DSI_DATA;
                  end
               end
            end
            PH_DSI_DATA: begin
               info_in   = info_ff - 32'd1;
               res_valid = 1'b1;
               res_code  = FC_INFO_BYTE;
               res_value = {24'd0, b};
               if (info_ff == 32'd1) begin
                  phase_in = PH_IDLE;
                  res_last = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         REG_ES_TAG:     csr_prdata = {24'd0, es_tag_ff};
         REG_CONFIG_TAG: csr_prdata = {24'd0, config_tag_ff};
         REG_INFO_TAG:   csr_prdata = {24'd0, info_tag_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // Hold parse state, registers and the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         es_tag_ff     <= 8'd3;
         config_tag_ff <= 8'd4;
         info_tag_ff   <= 8'd5;
         phase_ff      <= PH_IDLE;
         size_acc_ff   <= 32'd0;
         shift_ff      <= 32'd0;
         count_ff      <= 3'd0;
         flags_ff      <= 3'd0;
         url_ff        <= 8'd0;
         config_len_ff <= 32'd0;
         info_ff       <= 32'd0;
         remain_ff     <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_ES_TAG:     es_tag_ff     <= csr_pwdata[7:0];
               REG_CONFIG_TAG: config_tag_ff <= csr_pwdata[7:0];
               REG_INFO_TAG:   info_tag_ff   <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff      <= phase_in;
            size_acc_ff   <= size_acc_in;
            shift_ff      <= shift_in;
            count_ff      <= count_in;
            flags_ff      <= flags_in;
            url_ff        <= url_in;
            config_len_ff <= config_len_in;
            info_ff       <= info_in;
            remain_ff     <= remain_in;
            rsp_valid_ff  <= res_valid;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Result payload, loaded with each accepted byte
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_code_ff   <= res_code;
         rsp_value_ff  <= res_value;
         rsp_status_ff <= res_status;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_code  = rsp_code_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

### sv/esdp_checker.sv
// ----------------------------------------------------------------------------
// esdp_checker
// Port-level checks on the result channel of the ES descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module esdp_checker
   import esdp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_field_code,
   input wire logic [31:0] rsp_field_value,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_last
);

   logic        rsp_stall;
   logic [38:0] rsp_payload;
   logic        rsp_err;
   logic        rsp_end_zero;
   logic        req_take;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_field_code, rsp_field_value, rsp_status, rsp_last};
   assign rsp_err      = rsp_valid && (rsp_status != ST_OK);
   assign rsp_end_zero = (rsp_field_code == FC_END) && (rsp_field_value == 32'd0) && rsp_last;
   assign req_take     = req_valid && req_ready;

   // A stalled result holds
   `ESDP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload))

   // Errors end the frame with a zero end marker
   `ESDP_ASSERT_IMPLY(a_err_end, rsp_err, rsp_end_zero)

   // An end marker always closes the frame
   `ESDP_ASSERT_IMPLY(a_end_last, rsp_valid && rsp_field_code == FC_END, rsp_last)

   // No result without a byte taken in the cycle before
   `ESDP_ASSERT_NEXT_ANY(a_rsp_source, !rsp_valid && !req_take, !rsp_valid)

endmodule

bind es_descriptor_parser esdp_checker u_esdp_checker (.*);

`default_nettype wire
